/* src/hrg_pkg.sv */
`timescale 1ns / 1ps

package hrg_pkg;

  localparam int HUE_W  = 9;
  localparam int SAT_W  = 7;
  localparam int CHAN_W = 8;
  localparam int REM_W  = 6;
  localparam int K_W    = 13;
  localparam int NUM_W  = 21;

  localparam logic [HUE_W-1:0] HUE_TURN   = 9'd360;
  localparam logic [HUE_W-1:0] SECTOR_DEG = 9'd60;
  localparam logic [SAT_W-1:0] SAT_FULL   = 7'd100;
  localparam logic [K_W-1:0]   RATIO_DEN  = 13'd6000;
  localparam logic [NUM_W-1:0] RATIO_HALF = 21'd3000;

  // floor(n / 6000) == (n * RECIP_MUL) >> RECIP_SHIFT for every n below 2**21
  localparam int RECIP_SHIFT = 35;
  localparam int RECIP_W     = 23;
  localparam longint unsigned RECIP_FULL =
    ((64'd1 << RECIP_SHIFT) + 64'd5999) / 64'd6000;
  localparam logic [RECIP_W-1:0] RECIP_MUL = RECIP_FULL[RECIP_W-1:0];
  localparam int PROD_W = NUM_W + RECIP_W;

  typedef enum logic [2:0] {
    SEC_RED_YEL  = 3'd0,
    SEC_YEL_GRN  = 3'd1,
    SEC_GRN_CYN  = 3'd2,
    SEC_CYN_BLU  = 3'd3,
    SEC_BLU_MAG  = 3'd4,
    SEC_MAG_RED  = 3'd5
  } sector_t;

  // gamma curve, built at elaboration from exact integer compares
  localparam int BIG_W = 144;
  localparam int GAMMA_FLOOR = 25;
  localparam int GAMMA_SPAN  = 230;

  typedef logic [255:0][CHAN_W-1:0] gamma_lut_t;

  function automatic logic [CHAN_W-1:0] gamma_value(input int x);
    logic [BIG_W-1:0] lhs;
    logic [BIG_W-1:0] rhs;
    int lo;
    int hi;
    int mid;
    lhs = BIG_W'(32);
    for (int i = 0; i < 5; i++) lhs = lhs * BIG_W'(GAMMA_SPAN);
    for (int i = 0; i < 11; i++) lhs = lhs * BIG_W'(x);
    lo = 0;
    hi = GAMMA_SPAN;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      rhs = BIG_W'(1);
      for (int i = 0; i < 5; i++) rhs = rhs * BIG_W'(2 * mid - 1);
      for (int i = 0; i < 11; i++) rhs = rhs * BIG_W'(255);
      if (lhs >= rhs) begin
        lo = mid;
      end else begin
        hi = mid - 1;
      end
    end
    if (x == 0) begin
      return '0;
    end
    return CHAN_W'(GAMMA_FLOOR + lo);
  endfunction

  function automatic gamma_lut_t gamma_build();
    gamma_lut_t lut;
    for (int i = 0; i < 256; i++) lut[i] = gamma_value(i);
    return lut;
  endfunction

  localparam gamma_lut_t GAMMA_LUT = gamma_build();

endpackage

/* src/hrg_in_if.sv */
`timescale 1ns / 1ps

interface hrg_in_if;
  logic                         valid;
  logic                         ready;
  logic                         enable;
  logic [hrg_pkg::HUE_W-1:0]    hue;
  logic [hrg_pkg::SAT_W-1:0]    saturation;
  logic [hrg_pkg::CHAN_W-1:0]   brightness;

  modport source (output valid, enable, hue, saturation, brightness, input ready);
  modport sink (input valid, enable, hue, saturation, brightness, output ready);
endinterface

/* src/hrg_out_if.sv */
`timescale 1ns / 1ps

interface hrg_out_if;
  logic                         valid;
  logic                         ready;
  logic [hrg_pkg::CHAN_W-1:0]   red;
  logic [hrg_pkg::CHAN_W-1:0]   green;
  logic [hrg_pkg::CHAN_W-1:0]   blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

/* src/hsv_to_rgb_gamma_top.sv */
`timescale 1ns / 1ps

// channel  dir  beat contents
// pixel    in   enable, hue, saturation, brightness
// color    out  red, green, blue
//
// five register stages: gamma/hue wrap, sector and ratios, scale by v,
// reciprocal multiply for the divide by 6000, output select
// one beat per cycle while the output is ready
// each stage holds only while it is full and the stage after it is held,
// so bubbles close up and a waiting result blocks the input only once all
// five stages are full
// rst clears the valid bits only

module hsv_to_rgb_gamma_top (
  input  logic          clk,
  input  logic          rst,
  hrg_in_if.sink        pixel,
  hrg_out_if.source     color
);

  localparam int CW = hrg_pkg::CHAN_W;
  localparam int KW = hrg_pkg::K_W;
  localparam int NW = hrg_pkg::NUM_W;

  // stage valids and advance enables
  logic s1_valid, s2_valid, s3_valid, s4_valid;
  logic adv1, adv2, adv3, adv4, adv5;

  assign adv5 = !color.valid || color.ready;
  assign adv4 = !s4_valid || adv5;
  assign adv3 = !s3_valid || adv4;
  assign adv2 = !s2_valid || adv3;
  assign adv1 = !s1_valid || adv2;
  assign pixel.ready = adv1;

  // stage 1
  logic                        s1_en;
  logic [hrg_pkg::HUE_W-1:0]   s1_hh;
  logic [hrg_pkg::SAT_W-1:0]   s1_sat;
  logic [CW-1:0]               s1_v;

  logic [hrg_pkg::HUE_W-1:0]   hh_next;
  logic [hrg_pkg::SAT_W-1:0]   sat_next;

  always_comb begin
    hh_next  = (pixel.hue >= hrg_pkg::HUE_TURN) ? pixel.hue - hrg_pkg::HUE_TURN : pixel.hue;
    sat_next = (pixel.saturation > hrg_pkg::SAT_FULL) ? hrg_pkg::SAT_FULL : pixel.saturation;
  end

  // stage 2
  logic                        s2_en;
  logic                        s2_grey;
  hrg_pkg::sector_t            s2_sector;
  logic [CW-1:0]               s2_v;
  logic [KW-1:0]               s2_kp, s2_kq, s2_kt;

  hrg_pkg::sector_t            sector_next;
  logic [hrg_pkg::HUE_W-1:0]   base_next;
  logic [hrg_pkg::REM_W-1:0]   rem_next;
  logic [hrg_pkg::REM_W-1:0]   rem_inv;
  logic [KW-1:0]               kp_next, kq_next, kt_next;

  always_comb begin
    priority if (s1_hh >= 9'(hrg_pkg::SECTOR_DEG * 5)) begin
      sector_next = hrg_pkg::SEC_MAG_RED;
      base_next   = 9'(hrg_pkg::SECTOR_DEG * 5);
    end else if (s1_hh >= 9'(hrg_pkg::SECTOR_DEG * 4)) begin
      sector_next = hrg_pkg::SEC_BLU_MAG;
      base_next   = 9'(hrg_pkg::SECTOR_DEG * 4);
    end else if (s1_hh >= 9'(hrg_pkg::SECTOR_DEG * 3)) begin
      sector_next = hrg_pkg::SEC_CYN_BLU;
      base_next   = 9'(hrg_pkg::SECTOR_DEG * 3);
    end else if (s1_hh >= 9'(hrg_pkg::SECTOR_DEG * 2)) begin
      sector_next = hrg_pkg::SEC_GRN_CYN;
      base_next   = 9'(hrg_pkg::SECTOR_DEG * 2);
    end else if (s1_hh >= hrg_pkg::SECTOR_DEG) begin
      sector_next = hrg_pkg::SEC_YEL_GRN;
      base_next   = hrg_pkg::SECTOR_DEG;
    end else begin
      sector_next = hrg_pkg::SEC_RED_YEL;
      base_next   = '0;
    end
    rem_next = hrg_pkg::REM_W'(s1_hh - base_next);
    rem_inv  = hrg_pkg::REM_W'(hrg_pkg::SECTOR_DEG) - rem_next;
    kp_next  = KW'(hrg_pkg::SAT_FULL - s1_sat) * KW'(hrg_pkg::SECTOR_DEG);
    kq_next  = hrg_pkg::RATIO_DEN - KW'(s1_sat) * KW'(rem_next);
    kt_next  = hrg_pkg::RATIO_DEN - KW'(s1_sat) * KW'(rem_inv);
  end

  // stage 3: numerators with the rounding half added
  logic                        s3_en;
  logic                        s3_grey;
  hrg_pkg::sector_t            s3_sector;
  logic [CW-1:0]               s3_v;
  logic [NW-1:0]               s3_np, s3_nq, s3_nt;

  // stage 4: quotients by 6000
  logic                        s4_en;
  logic                        s4_grey;
  hrg_pkg::sector_t            s4_sector;
  logic [CW-1:0]               s4_v;
  logic [CW-1:0]               s4_p, s4_q, s4_t;

  logic [hrg_pkg::PROD_W-1:0]  prod_p, prod_q, prod_t;

  always_comb begin
    prod_p = hrg_pkg::PROD_W'(s3_np) * hrg_pkg::PROD_W'(hrg_pkg::RECIP_MUL);
    prod_q = hrg_pkg::PROD_W'(s3_nq) * hrg_pkg::PROD_W'(hrg_pkg::RECIP_MUL);
    prod_t = hrg_pkg::PROD_W'(s3_nt) * hrg_pkg::PROD_W'(hrg_pkg::RECIP_MUL);
  end

  // stage 5: output select
  logic [CW-1:0] red_next, green_next, blue_next;

  always_comb begin
    unique case (s4_sector)
      hrg_pkg::SEC_RED_YEL: begin
        red_next = s4_v; green_next = s4_t; blue_next = s4_p;
      end
      hrg_pkg::SEC_YEL_GRN: begin
        red_next = s4_q; green_next = s4_v; blue_next = s4_p;
      end
      hrg_pkg::SEC_GRN_CYN: begin
        red_next = s4_p; green_next = s4_v; blue_next = s4_t;
      end
      hrg_pkg::SEC_CYN_BLU: begin
        red_next = s4_p; green_next = s4_q; blue_next = s4_v;
      end
      hrg_pkg::SEC_BLU_MAG: begin
        red_next = s4_t; green_next = s4_p; blue_next = s4_v;
      end
      default: begin
        red_next = s4_v; green_next = s4_p; blue_next = s4_q;
      end
    endcase
    if (s4_grey) begin
      red_next   = s4_v;
      green_next = s4_v;
      blue_next  = s4_v;
    end
    if (!s4_en) begin
      red_next   = '0;
      green_next = '0;
      blue_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      s2_valid    <= 1'b0;
      s3_valid    <= 1'b0;
      s4_valid    <= 1'b0;
      color.valid <= 1'b0;
    end else begin
      if (adv1) s1_valid <= pixel.valid;
      if (adv2) s2_valid <= s1_valid;
      if (adv3) s3_valid <= s2_valid;
      if (adv4) s4_valid <= s3_valid;
      if (adv5) color.valid <= s4_valid;
    end

    if (adv1) begin
      s1_en  <= pixel.enable;
      s1_hh  <= hh_next;
      s1_sat <= sat_next;
      s1_v   <= hrg_pkg::GAMMA_LUT[pixel.brightness];
    end
    if (adv2) begin
      s2_en     <= s1_en;
      s2_grey   <= (s1_sat == '0);
      s2_sector <= sector_next;
      s2_v      <= s1_v;
      s2_kp     <= kp_next;
      s2_kq     <= kq_next;
      s2_kt     <= kt_next;
    end
    if (adv3) begin
      s3_en     <= s2_en;
      s3_grey   <= s2_grey;
      s3_sector <= s2_sector;
      s3_v      <= s2_v;
      s3_np     <= NW'(s2_v) * NW'(s2_kp) + hrg_pkg::RATIO_HALF;
      s3_nq     <= NW'(s2_v) * NW'(s2_kq) + hrg_pkg::RATIO_HALF;
      s3_nt     <= NW'(s2_v) * NW'(s2_kt) + hrg_pkg::RATIO_HALF;
    end
    if (adv4) begin
      s4_en     <= s3_en;
      s4_grey   <= s3_grey;
      s4_sector <= s3_sector;
      s4_v      <= s3_v;
      s4_p      <= prod_p[hrg_pkg::RECIP_SHIFT +: CW];
      s4_q      <= prod_q[hrg_pkg::RECIP_SHIFT +: CW];
      s4_t      <= prod_t[hrg_pkg::RECIP_SHIFT +: CW];
    end
    if (adv5) begin
      color.red   <= red_next;
      color.green <= green_next;
      color.blue  <= blue_next;
    end
  end

endmodule
